FILE: sv/convolution_reverb_mix_core_assert.svh
// assertion macros used by the convolution reverb core
`ifndef CONVOLUTION_REVERB_MIX_CORE_ASSERT_SVH
`define CONVOLUTION_REVERB_MIX_CORE_ASSERT_SVH

// property must hold on every rising clock edge outside reset
`define CRM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CRM_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: sv/crm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package crm_pkg;

  // field widths
  localparam int SMP_W     = 16;
  localparam int IDX_W     = 10;
  localparam int TC_W      = 11;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 32;
  localparam int IN_DATA_W = 32;

  // operation codes carried in tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN  = 2'd2;

  // register reset values
  localparam logic [TC_W-1:0]          TAP_COUNT_RST = 11'd1;
  localparam logic signed [GAIN_W-1:0] WET_GAIN_RST  = 16'sd4096;
  localparam logic signed [GAIN_W-1:0] DRY_GAIN_RST  = 16'sd0;

  // sequencer to datapath controls
  typedef struct packed {
    logic start;
    logic mul_en;
    logic mul_dry;
    logic wet_en;
  } mac_ctrl_t;

  // mixed and saturated result
  typedef struct packed {
    logic [SMP_W-1:0] smp;
    logic             clip;
  } mac_res_t;

endpackage
`default_nettype wire

FILE: sv/crm_store.sv
`timescale 1ns / 1ps
`default_nettype none
module crm_store import crm_pkg::*; #(
  parameter int TAPS  = 1024,
  parameter int PTR_W = 10
) (
  input  logic             clk_i,
  input  logic             tap_we_i,
  input  logic [PTR_W-1:0] tap_waddr_i,
  input  logic [SMP_W-1:0] tap_wdata_i,
  input  logic [PTR_W-1:0] tap_raddr_i,
  output logic [SMP_W-1:0] tap_rdata_o,
  input  logic             dly_we_i,
  input  logic [PTR_W-1:0] dly_waddr_i,
  input  logic [SMP_W-1:0] dly_wdata_i,
  input  logic [PTR_W-1:0] dly_raddr_i,
  output logic [SMP_W-1:0] dly_rdata_o
);

  logic [SMP_W-1:0] tap_mem [TAPS];
  logic [SMP_W-1:0] dly_mem [TAPS];
  logic [SMP_W-1:0] tap_rdata_q;
  logic [SMP_W-1:0] dly_rdata_q;

  // impulse response taps
  always_ff @(posedge clk_i) begin
    if (tap_we_i) begin
      tap_mem[tap_waddr_i] <= tap_wdata_i;
    end
    tap_rdata_q <= tap_mem[tap_raddr_i];
  end

  // circular sample history
  always_ff @(posedge clk_i) begin
    if (dly_we_i) begin
      dly_mem[dly_waddr_i] <= dly_wdata_i;
    end
    dly_rdata_q <= dly_mem[dly_raddr_i];
  end

  assign tap_rdata_o = tap_rdata_q;
  assign dly_rdata_o = dly_rdata_q;

endmodule
`default_nettype wire

FILE: sv/crm_mac.sv
`timescale 1ns / 1ps
`default_nettype none
module crm_mac import crm_pkg::*; #(
  parameter int ACC_W = 42
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [SMP_W-1:0]  tap_i,
  input  logic signed [SMP_W-1:0]  dly_i,
  input  logic signed [SMP_W-1:0]  smp_i,
  input  logic signed [GAIN_W-1:0] wet_gain_i,
  input  logic signed [GAIN_W-1:0] dry_gain_i,
  output logic                     busy_o,
  output mac_res_t                 res_o
);

  localparam int WET_W  = ACC_W + GAIN_W;
  localparam int TOT_W  = WET_W + 1;
  localparam int RND_SH = 27;
  localparam int DRY_SH = 15;
  localparam int R_W    = TOT_W - RND_SH;

  localparam logic signed [TOT_W-1:0] RND_ADD = TOT_W'(1) <<< (RND_SH - 1);
  localparam logic signed [R_W-1:0]   SAT_MAX = R_W'(32767);
  localparam logic signed [R_W-1:0]   SAT_MIN = R_W'(-32768);

  logic signed [SMP_W-1:0]  mul_a;
  logic signed [SMP_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic                     prod_dry_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] dry_q;
  logic signed [WET_W-1:0]  wet_d;
  logic signed [WET_W-1:0]  wet_q;
  logic signed [TOT_W-1:0]  tot;
  logic signed [R_W-1:0]    rnd;

  // shared multiplier: tap times history, or sample times dry gain
  always_comb begin
    mul_a  = ctrl_i.mul_dry ? smp_i : tap_i;
    mul_b  = ctrl_i.mul_dry ? dry_gain_i : dly_i;
    prod_d = mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_dry_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
      prod_dry_q <= ctrl_i.mul_dry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // accumulate products, park the dry term aside
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= '0;
    end else if (prod_vld_q && !prod_dry_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (prod_vld_q && prod_dry_q) begin
      dry_q <= prod_q;
    end
  end

  // wet gain on the finished sum
  assign wet_d = acc_q * wet_gain_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wet_en) begin
      wet_q <= wet_d;
    end
  end

  // mix, round half up to q0.15, saturate
  always_comb begin
    tot = TOT_W'(wet_q) + (TOT_W'(dry_q) <<< DRY_SH) + RND_ADD;
    rnd = R_W'(tot >>> RND_SH);
    if (rnd > SAT_MAX) begin
      res_o.smp  = 16'h7fff;
      res_o.clip = 1'b1;
    end else if (rnd < SAT_MIN) begin
      res_o.smp  = 16'h8000;
      res_o.clip = 1'b1;
    end else begin
      res_o.smp  = rnd[SMP_W-1:0];
      res_o.clip = 1'b0;
    end
  end

  assign busy_o = prod_vld_q;

endmodule
`default_nettype wire

FILE: sv/convolution_reverb_mix_core.sv
// A sample word's result is the multiply-accumulate over n taps plus the dry term,
// n = min(tap_count, TAPS); a tap load word gives no result.
// A new sample word is not taken until the last result enters the output register, which waits
// on the result side; the single shared multiply-accumulate unit walks one tap per cycle.
// Reset: registers return to their defaults and the delay line is cleared in one pass over all TAPS
// entries with tready low; configuration writes are taken during that pass. Taps are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "convolution_reverb_mix_core_assert.svh"
module convolution_reverb_mix_core import crm_pkg::*; #(
  parameter int TAPS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,   // tap_index[9:0], value[25:10], zero[31:26]
  input  logic [0:0]           s_axis_tuser,   // operation[0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [SMP_W-1:0]     m_axis_tdata,   // out_sample[15:0]
  output logic [0:0]           m_axis_tuser,   // clipped[0]
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GAIN_W-1:0]    cfg_data_i
);

  localparam int PTR_W = $clog2(TAPS);
  localparam int CNT_W = $clog2(TAPS + 1);
  localparam int CMP_W = (CNT_W > TC_W) ? CNT_W : TC_W;
  localparam int ACC_W = PROD_W + $clog2(TAPS);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TAPS - 1);
  localparam logic [31:0]      TAPS_U   = 32'(TAPS);

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_WET  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]               state_q;
  logic [TC_W-1:0]          tap_count_q;
  logic signed [GAIN_W-1:0] wet_gain_q;
  logic signed [GAIN_W-1:0] dry_gain_q;
  logic [PTR_W-1:0]         wp_q;
  logic [PTR_W-1:0]         pos_q;
  logic [PTR_W-1:0]         clr_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [CNT_W-1:0]         n_q;
  logic                     first_q;
  logic                     rd_vld_q;
  logic signed [SMP_W-1:0]  smp_q;
  logic                     out_vld_q;
  logic [SMP_W-1:0]         out_smp_q;
  logic                     out_clip_q;

  logic                     in_op;
  logic [IDX_W-1:0]         in_idx;
  logic [SMP_W-1:0]         in_val;
  logic                     in_acc;
  logic                     smp_acc;
  logic [CMP_W-1:0]         tc_ext;
  logic [CNT_W-1:0]         n_eff;
  logic                     issue;
  logic                     out_free;
  logic [PTR_W-1:0]         wp_next;
  logic [PTR_W-1:0]         pos_prev;
  logic [PTR_W-1:0]         clr_next;
  logic                     clip_unsat;

  logic                     tap_we;
  logic                     dly_we;
  logic [PTR_W-1:0]         dly_waddr;
  logic [SMP_W-1:0]         dly_wdata;
  logic [SMP_W-1:0]         tap_rdata;
  logic [SMP_W-1:0]         dly_rdata;

  mac_ctrl_t                mac_ctrl;
  mac_res_t                 mac_res;
  logic                     mac_busy;

  // input word fields
  assign in_op   = s_axis_tuser[0];
  assign in_idx  = s_axis_tdata[IDX_W-1:0];
  assign in_val  = s_axis_tdata[IDX_W+SMP_W-1:IDX_W];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign smp_acc = in_acc && (in_op == OP_SAMPLE);

  assign s_axis_tready = (state_q == S_IDLE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RST;
      wet_gain_q  <= WET_GAIN_RST;
      dry_gain_q  <= DRY_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TAP_COUNT: tap_count_q <= cfg_data_i[TC_W-1:0];
        CFG_WET_GAIN:  wet_gain_q  <= cfg_data_i;
        CFG_DRY_GAIN:  dry_gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // taps in use, limited to the store depth
  always_comb begin
    tc_ext = CMP_W'(tap_count_q);
    n_eff  = (tc_ext > CMP_W'(TAPS)) ? CNT_W'(TAPS) : CNT_W'(tc_ext);
  end

  // circular pointer steps
  assign wp_next  = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
  assign pos_prev = (pos_q == '0) ? PTR_LAST : pos_q - 1'b1;
  assign clr_next = (clr_q == PTR_LAST) ? '0 : clr_q + 1'b1;

  assign issue    = (state_q == S_MAC) && (cnt_q != n_q);
  assign out_free = !out_vld_q || m_axis_tready;

  // store write ports
  assign tap_we    = in_acc && (in_op == OP_LOAD) && (32'(in_idx) < TAPS_U);
  assign dly_we    = (state_q == S_CLR) || smp_acc;
  assign dly_waddr = (state_q == S_CLR) ? clr_q : wp_q;
  assign dly_wdata = (state_q == S_CLR) ? '0 : in_val;

  // datapath controls
  always_comb begin
    mac_ctrl.start   = smp_acc;
    mac_ctrl.mul_dry = (state_q == S_MAC) && first_q;
    mac_ctrl.mul_en  = rd_vld_q || mac_ctrl.mul_dry;
    mac_ctrl.wet_en  = (state_q == S_WET);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      wp_q     <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      n_q      <= '0;
      first_q  <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      first_q  <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_next;
          if (clr_q == PTR_LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (smp_acc) begin
            wp_q    <= wp_next;
            pos_q   <= wp_q;
            cnt_q   <= '0;
            n_q     <= n_eff;
            first_q <= 1'b1;
            state_q <= S_MAC;
          end
        end
        S_MAC: begin
          if (issue) begin
            cnt_q <= cnt_q + CNT_W'(1);
            pos_q <= pos_prev;
          end else if (!first_q && !rd_vld_q && !mac_busy) begin
            state_q <= S_WET;
          end
        end
        S_WET: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // latched sample for the dry term
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      smp_q <= in_val;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && out_free) begin
      out_smp_q  <= mac_res.smp;
      out_clip_q <= mac_res.clip;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_smp_q;
  assign m_axis_tuser[0] = out_clip_q;

  crm_store #(
    .TAPS  (TAPS),
    .PTR_W (PTR_W)
  ) u_store (
    .clk_i       (clk_i),
    .tap_we_i    (tap_we),
    .tap_waddr_i (PTR_W'(in_idx)),
    .tap_wdata_i (in_val),
    .tap_raddr_i (cnt_q[PTR_W-1:0]),
    .tap_rdata_o (tap_rdata),
    .dly_we_i    (dly_we),
    .dly_waddr_i (dly_waddr),
    .dly_wdata_i (dly_wdata),
    .dly_raddr_i (pos_q),
    .dly_rdata_o (dly_rdata)
  );

  crm_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .tap_i      (tap_rdata),
    .dly_i      (dly_rdata),
    .smp_i      (smp_q),
    .wet_gain_i (wet_gain_q),
    .dry_gain_i (dry_gain_q),
    .busy_o     (mac_busy),
    .res_o      (mac_res)
  );

  // clip flag set on a word that is not a rail value
  assign clip_unsat = m_axis_tuser[0] && (m_axis_tdata != 16'h7fff) &&
                      (m_axis_tdata != 16'h8000);

  // checks
  `CRM_ASSERT(a_busy_after_sample, smp_acc |=> !s_axis_tready, "ready right after a sample word")
  `CRM_ASSERT(a_out_from_seq, $rose(m_axis_tvalid) |-> $past(state_q == S_OUT), "stray output word")
  `CRM_ASSERT_NEVER(a_clip_saturates, m_axis_tvalid && clip_unsat, "clip flag on unsaturated word")
  `CRM_ASSERT(a_cnt_bound, (state_q == S_MAC) |-> (cnt_q <= n_q), "tap counter ran past tap count")
  `CRM_ASSERT(a_wp_moves_on_sample, !smp_acc |=> $stable(wp_q), "write pointer moved without a sample")
  `CRM_ASSERT_NEVER(a_idle_mac_quiet, (state_q == S_IDLE) && mac_busy, "multiplier busy while idle")

endmodule
`default_nettype wire
